[rtl/bwlru_pkg.sv]
// Shared types, constants and helpers for the byte-weighted LRU cache.
package bwlru_pkg;

	localparam int ENTRIES_DEF = 64;
	localparam int KEY_W       = 28;
	localparam int SIZE_W      = 32;
	localparam int CAP_W       = 41;
	localparam int TOT_W       = 48;
	localparam int CNT7_W      = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64'd536870912);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_EVICT,
		ST_INSERT,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_HIT,
		OP_EVICT,
		OP_INSERT
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
	} cmd_t;

	function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
	                                             input logic [SIZE_W-1:0] b);
		logic [TOT_W:0] s;
		s = {1'b0, a} + (TOT_W+1)'(b);
		return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
	endfunction

endpackage

[rtl/bwlru_cell.sv]
// One cache cell: key, size, valid and recency rank of a single slot.
module bwlru_cell
	import bwlru_pkg::*;
#(
	parameter int RW = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [RW-1:0]     hit_rank,
	input  logic [RW-1:0]     victim_rank,
	input  logic              free_seen_in,
	output logic              free_seen_out,
	output logic              match,
	output logic [RW-1:0]     rank_masked,
	output logic [SIZE_W-1:0] size_masked
);

	logic              valid_q;
	logic [RW-1:0]     rank_q;
	logic [KEY_W-1:0]  key_q;
	logic [SIZE_W-1:0] size_q;
	logic              slot;
	logic              victim;

	assign match         = valid_q && (key_q == cmd.key);
	assign victim        = valid_q && (rank_q == victim_rank);
	assign rank_masked   = match ? rank_q : '0;
	assign size_masked   = victim ? size_q : '0;
	assign slot          = !valid_q && !free_seen_in;
	assign free_seen_out = free_seen_in || !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else begin
			case (cmd.op)
				OP_HIT: begin
					if (match)
						rank_q <= '0;
					else if (valid_q && rank_q < hit_rank)
						rank_q <= rank_q + RW'(1);
				end
				OP_EVICT: begin
					if (victim)
						valid_q <= 1'b0;
				end
				OP_INSERT: begin
					if (valid_q)
						rank_q <= rank_q + RW'(1);
					else if (slot) begin
						valid_q <= 1'b1;
						rank_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// key and size are payload, loaded only into the chosen free slot
	always_ff @(posedge clk) begin
		if (cmd.op == OP_INSERT && slot) begin
			key_q  <= cmd.key;
			size_q <= cmd.size;
		end
	end

endmodule

[rtl/byte_weighted_lru_cache_unit.sv]
// Top level of the byte-weighted exact-LRU cache: control, totals and the cell row.
// Flow: hit LOOK, DONE; miss LOOK, EVICT until room, INSERT if inserted, then DONE.
// Throughput: one access at a time; the eviction loop pops one LRU entry per cycle.
// Input is taken while a finished result waits in the output register.
// Reset (arst_n low): store empty, all totals zero, capacity 2^29 bytes.
// No clearing pass: cell valid bits are flip-flops cleared at once.
module byte_weighted_lru_cache_unit
	import bwlru_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [CAP_W-1:0] cfg_wdata,      // capacity_bytes
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [63:0]      s_tdata,        // tensor_index[11:0], expert_id[27:12],
	                                         // slice_size[59:28], zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [255:0]     m_tdata         // hit[0], inserted[1], evicted_now[8:2],
	                                         // used_bytes[49:9], entry_count[56:50],
	                                         // hit_total[104:57], miss_total[152:105],
	                                         // miss_byte_total[200:153],
	                                         // eviction_total[248:201], zero pad
);

	localparam int RW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int EW = (CW > CNT7_W) ? CW : CNT7_W;

	state_t state_q, state_d;

	logic [CAP_W-1:0]  cap_q;
	logic [KEY_W-1:0]  key_q;
	logic [SIZE_W-1:0] size_q;
	logic [CAP_W-1:0]  resident_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     evicted_q;
	logic              hit_q;
	logic              inserted_q;
	logic [TOT_W-1:0]  hit_tot_q, miss_tot_q, mbyte_tot_q, evict_tot_q;

	cmd_t              cmd;
	logic [RW-1:0]     hit_rank, victim_rank;
	logic              any_match;
	logic [SIZE_W-1:0] victim_size;
	logic              need_room, fits, full, out_free;

	logic [ENTRIES:0]  free_chain;
	logic [ENTRIES-1:0]             match_v;
	logic [ENTRIES-1:0][RW-1:0]     rank_v;
	logic [ENTRIES-1:0][SIZE_W-1:0] size_v;

	assign victim_rank = RW'(count_q - CW'(1));
	assign free_chain[0] = 1'b0;

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			bwlru_cell #(.RW(RW)) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.cmd          (cmd),
				.hit_rank     (hit_rank),
				.victim_rank  (victim_rank),
				.free_seen_in (free_chain[g]),
				.free_seen_out(free_chain[g+1]),
				.match        (match_v[g]),
				.rank_masked  (rank_v[g]),
				.size_masked  (size_v[g])
			);
		end
	endgenerate

	// keys and ranks are unique among valid cells, so a plain OR picks the one hit / victim
	always_comb begin
		hit_rank    = '0;
		victim_size = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_rank    = hit_rank | rank_v[i];
			victim_size = victim_size | size_v[i];
		end
	end
	assign any_match = |match_v;

	assign need_room = (({1'b0, resident_q} + (CAP_W+1)'(size_q)) > {1'b0, cap_q})
	                   && (count_q != '0);
	assign fits      = (CAP_W'(size_q) <= cap_q);
	assign full      = (count_q == CW'(ENTRIES));
	assign out_free  = !m_tvalid || m_tready;
	assign s_tready  = (state_q == ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_LOOK;
			ST_LOOK:   state_d = any_match ? ST_DONE : ST_EVICT;
			ST_EVICT: begin
				if (need_room)
					state_d = ST_EVICT;
				else if (fits)
					state_d = ST_INSERT;
				else
					state_d = ST_DONE;
			end
			ST_INSERT: state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// cell command
	always_comb begin
		cmd.key  = key_q;
		cmd.size = size_q;
		cmd.op   = OP_NONE;
		case (state_q)
			ST_LOOK:   if (any_match) cmd.op = OP_HIT;
			ST_EVICT:  if (need_room || (fits && full)) cmd.op = OP_EVICT;
			ST_INSERT: cmd.op = OP_INSERT;
			default:   cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			resident_q  <= '0;
			count_q     <= '0;
			evicted_q   <= '0;
			hit_q       <= 1'b0;
			inserted_q  <= 1'b0;
			hit_tot_q   <= '0;
			miss_tot_q  <= '0;
			mbyte_tot_q <= '0;
			evict_tot_q <= '0;
			m_tvalid    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen)
				cap_q <= cfg_wdata;
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					evicted_q  <= '0;
					hit_q      <= 1'b0;
					inserted_q <= 1'b0;
				end
				ST_LOOK: begin
					if (any_match) begin
						hit_q     <= 1'b1;
						hit_tot_q <= sat_add(hit_tot_q, SIZE_W'(1));
					end else begin
						miss_tot_q  <= sat_add(miss_tot_q, SIZE_W'(1));
						mbyte_tot_q <= sat_add(mbyte_tot_q, size_q);
					end
				end
				ST_EVICT: begin
					if (cmd.op == OP_EVICT) begin
						resident_q  <= resident_q - CAP_W'(victim_size);
						count_q     <= count_q - CW'(1);
						evicted_q   <= evicted_q + CW'(1);
						evict_tot_q <= sat_add(evict_tot_q, SIZE_W'(1));
					end
				end
				ST_INSERT: begin
					resident_q <= resident_q + CAP_W'(size_q);
					count_q    <= count_q + CW'(1);
					inserted_q <= 1'b1;
				end
				ST_DONE: begin
					if (out_free)
						m_tvalid <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// input payload capture and result assembly
	logic [EW-1:0] ev_ext, cnt_ext;
	assign ev_ext  = EW'(evicted_q);
	assign cnt_ext = EW'(count_q);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			key_q  <= s_tdata[27:0];
			size_q <= s_tdata[59:28];
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata[0]       <= hit_q;
			m_tdata[1]       <= inserted_q;
			m_tdata[8:2]     <= (ev_ext > EW'(127)) ? 7'd127 : ev_ext[6:0];
			m_tdata[49:9]    <= resident_q;
			m_tdata[56:50]   <= (cnt_ext > EW'(127)) ? 7'd127 : cnt_ext[6:0];
			m_tdata[104:57]  <= hit_tot_q;
			m_tdata[152:105] <= miss_tot_q;
			m_tdata[200:153] <= mbyte_tot_q;
			m_tdata[248:201] <= evict_tot_q;
			m_tdata[255:249] <= '0;
		end
	end

endmodule

[rtl/bwlru_checker.sv]
// Port-level checks for the byte-weighted LRU cache, bound to the top level.
module bwlru_checker
	import bwlru_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [255:0]     m_tdata
);

	a_in_once: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");

	a_hit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("hit and insert together");

	a_hit_noevict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[8:2] == 7'd0)
		else $error("eviction on a hit");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(m_tdata[56:50]) <= 32'(ENTRIES))
		else $error("entry count above slot bound");

endmodule

bind byte_weighted_lru_cache_unit bwlru_checker #(.ENTRIES(ENTRIES)) u_bwlru_checker (.*);

[tb/tb.sv]
// Testbench for the byte-weighted exact-LRU cache: directed and random accesses against a predictor.
`timescale 1ns / 1ps

module tb;
	import bwlru_pkg::*;

	localparam int N_SLOTS  = 64;
	localparam int LIMIT    = 800000;
	localparam logic [CAP_W-1:0] CAP_TOP = CAP_W'(64'h100_0000_0000);

	// one predicted result transfer
	typedef struct {
		logic              hit;
		logic              inserted;
		logic [6:0]        evicted_now;
		logic [CAP_W-1:0]  used_bytes;
		logic [6:0]        entry_count;
		logic [TOT_W-1:0]  hit_total;
		logic [TOT_W-1:0]  miss_total;
		logic [TOT_W-1:0]  miss_byte_total;
		logic [TOT_W-1:0]  eviction_total;
	} lookup_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [CAP_W-1:0]   cfg_wdata;
	logic               s_tvalid;
	logic               s_tready;
	logic [63:0]        s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [255:0]       m_tdata;

	byte_weighted_lru_cache_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// predictor state
	logic [KEY_W-1:0]  pk_key [N_SLOTS];
	logic [SIZE_W-1:0] pk_size[N_SLOTS];
	logic              pk_valid[N_SLOTS];
	int unsigned       pk_rank[N_SLOTS];
	int unsigned       pk_count;
	logic [63:0]       pk_resident;
	logic [63:0]       pk_cap;
	logic [TOT_W-1:0]  pk_hits, pk_misses, pk_miss_bytes, pk_evicts;

	lookup_result_t    pending_results[$];
	logic [KEY_W-1:0]  key_pool[24];

	int                send_idle_pct;
	int                recv_idle_pct;
	int                stall_left;
	int                mismatches;
	int                cycles;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic logic [TOT_W-1:0] sat48(input logic [TOT_W-1:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = 64'(a) + b;
		return (s > 64'hFFFF_FFFF_FFFF) ? {TOT_W{1'b1}} : s[TOT_W-1:0];
	endfunction

	task automatic drop_lru();
		for (int i = 0; i < N_SLOTS; i++)
			if (pk_valid[i] && pk_rank[i] == pk_count - 1) begin
				pk_valid[i] = 1'b0;
				pk_resident -= 64'(pk_size[i]);
				pk_count--;
				pk_evicts = sat48(pk_evicts, 64'd1);
				return;
			end
	endtask

	// Updates the predicted store for one access and returns what the block should report.
	task automatic predict_access(input logic [KEY_W-1:0] key, input logic [SIZE_W-1:0] sz,
	                              output lookup_result_t r);
		int found;
		int slot;
		int unsigned ev;
		int unsigned rk;
		found = -1;
		slot = -1;
		ev = 0;
		r.hit = 1'b0;
		r.inserted = 1'b0;
		for (int i = 0; i < N_SLOTS; i++)
			if (found < 0 && pk_valid[i] && pk_key[i] == key) found = i;
		if (found >= 0) begin
			rk = pk_rank[found];
			r.hit = 1'b1;
			pk_hits = sat48(pk_hits, 64'd1);
			for (int i = 0; i < N_SLOTS; i++)
				if (pk_valid[i] && pk_rank[i] < rk) pk_rank[i]++;
			pk_rank[found] = 0;
		end else begin
			pk_misses = sat48(pk_misses, 64'd1);
			pk_miss_bytes = sat48(pk_miss_bytes, 64'(sz));
			while (pk_resident + 64'(sz) > pk_cap && pk_count > 0) begin
				drop_lru();
				ev++;
			end
			if (64'(sz) <= pk_cap) begin
				if (pk_count >= N_SLOTS) begin
					drop_lru();
					ev++;
				end
				for (int i = 0; i < N_SLOTS; i++)
					if (slot < 0 && !pk_valid[i]) slot = i;
				if (slot >= 0) begin
					for (int i = 0; i < N_SLOTS; i++)
						if (pk_valid[i]) pk_rank[i]++;
					pk_valid[slot] = 1'b1;
					pk_key[slot] = key;
					pk_size[slot] = sz;
					pk_rank[slot] = 0;
					pk_count++;
					pk_resident += 64'(sz);
					r.inserted = 1'b1;
				end
			end
		end
		r.evicted_now = (ev > 127) ? 7'd127 : 7'(ev);
		r.used_bytes = pk_resident[CAP_W-1:0];
		r.entry_count = (pk_count > 127) ? 7'd127 : 7'(pk_count);
		r.hit_total = pk_hits;
		r.miss_total = pk_misses;
		r.miss_byte_total = pk_miss_bytes;
		r.eviction_total = pk_evicts;
	endtask

	// Offers one access and waits for its transfer; tvalid stays high for a following item.
	task automatic send_access(input logic [11:0] ti, input logic [15:0] ei,
	                           input logic [31:0] sz);
		lookup_result_t r;
		int gap;
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, sz, ei, ti};
		do @(posedge clk); while (!s_tready);
		predict_access({ti, ei}, sz, r);
		pending_results = {pending_results, r};
	endtask

	// Stops offering and waits until every predicted result has been taken.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen <= 1'b0;
		pk_cap = 64'(v);
	endtask

	task automatic send_key(input logic [KEY_W-1:0] key, input logic [31:0] sz);
		send_access(key[27:16], key[15:0], sz);
	endtask

	// result side: random ready, with long hold-offs on request
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
		if (exp !== act) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0d got %0d", name, exp, act);
		end
	endtask

	always @(posedge clk) begin
		lookup_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("result transfer with nothing expected");
			end else begin
				e = pending_results.pop_front();
				check_field("hit", 64'(e.hit), 64'(m_tdata[0]));
				check_field("inserted", 64'(e.inserted), 64'(m_tdata[1]));
				check_field("evicted_now", 64'(e.evicted_now), 64'(m_tdata[8:2]));
				check_field("used_bytes", 64'(e.used_bytes), 64'(m_tdata[49:9]));
				check_field("entry_count", 64'(e.entry_count), 64'(m_tdata[56:50]));
				check_field("hit_total", 64'(e.hit_total), 64'(m_tdata[104:57]));
				check_field("miss_total", 64'(e.miss_total), 64'(m_tdata[152:105]));
				check_field("miss_byte_total", 64'(e.miss_byte_total), 64'(m_tdata[200:153]));
				check_field("eviction_total", 64'(e.eviction_total), 64'(m_tdata[248:201]));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("** byte_weighted_lru_cache_unit: FAILED **");
			$finish;
		end
	end

	// hits, misses, zero size, oversized entry and the extremes of each field
	task automatic test_basic_access();
		send_access(12'h000, 16'h0000, 32'd100);
		send_access(12'hFFF, 16'hFFFF, 32'd0);
		send_access(12'h000, 16'h0000, 32'd7);
		send_access(12'hFFF, 16'hFFFF, 32'd5);
		send_access(12'h555, 16'hAAAA, 32'h0FFF_FFFF);
		send_access(12'hAAA, 16'h5555, 32'h1000_0000);
		send_access(12'h123, 16'h4567, 32'h1000_0001);
		send_access(12'h000, 16'h0000, 32'd1);
		send_access(12'h321, 16'h7654, 32'hFFFF_FFFF);
		send_access(12'h000, 16'h0000, 32'd1);
	endtask

	// lowering the capacity below the resident bytes: hits keep everything
	task automatic test_capacity_lowered();
		set_capacity(CAP_W'(64'd4000));
		for (int i = 0; i < 6; i++) send_access(12'(i), 16'(i * 3), 32'd600);
		set_capacity(CAP_W'(64'd1000));
		send_access(12'd2, 16'd6, 32'd1);
		send_access(12'd5, 16'd15, 32'd1);
		send_access(12'd9, 16'd9, 32'd300);
	endtask

	// zero capacity still admits zero-size entries
	task automatic test_zero_capacity();
		set_capacity('0);
		send_access(12'd1, 16'd1, 32'd0);
		send_access(12'd2, 16'd2, 32'd1);
		send_access(12'd1, 16'd1, 32'd0);
	endtask

	// more distinct keys than slots: the slot bound evicts the LRU entry
	task automatic test_slot_bound();
		set_capacity(CAP_TOP);
		for (int i = 0; i < N_SLOTS + 6; i++) send_access(12'(i), 16'hBEEF, 32'd0);
		send_access(12'd10, 16'hBEEF, 32'd3);
		send_access(12'd0, 16'hBEEF, 32'd3);
	endtask

	task automatic random_phase(input int n, input logic [CAP_W-1:0] cap, input int size_shift);
		logic [31:0] sz;
		set_capacity(cap);
		for (int i = 0; i < n; i++) begin
			sz = $urandom() >> size_shift;
			if ($urandom_range(19) == 0) sz = $urandom();
			if ($urandom_range(99) < 75)
				send_key(key_pool[$urandom_range(23)], sz);
			else
				send_access(12'($urandom()), 16'($urandom()), sz);
		end
	endtask

	// receiver holds off while the sender keeps offering, then the sender waits out the backlog
	task automatic test_backpressure();
		set_capacity(CAP_W'(64'd536870912));
		@(posedge clk);
		stall_left = 300;
		for (int i = 0; i < 20; i++) send_key(key_pool[$urandom_range(23)], $urandom() >> 6);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		stall_left = 0;
		mismatches = 0;
		cycles = 0;
		send_idle_pct = 15;
		recv_idle_pct = 58;
		for (int i = 0; i < N_SLOTS; i++) begin
			pk_valid[i] = 1'b0;
			pk_rank[i] = 0;
			pk_key[i] = '0;
			pk_size[i] = '0;
		end
		pk_count = 0;
		pk_resident = 0;
		pk_cap = 64'd536870912;
		pk_hits = '0;
		pk_misses = '0;
		pk_miss_bytes = '0;
		pk_evicts = '0;
		for (int i = 0; i < 24; i++) key_pool[i] = KEY_W'($urandom());
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_access();
		test_capacity_lowered();
		test_zero_capacity();
		test_slot_bound();

		random_phase(100, CAP_W'(64'd536870912), 6);
		random_phase(100, CAP_TOP, 0);
		send_idle_pct = 58;
		recv_idle_pct = 15;
		random_phase(100, CAP_W'({$urandom(), $urandom()} & 64'hFF_FFFF_FFFF), 0);
		random_phase(100, CAP_W'(64'd20000), 20);
		test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(100, CAP_W'(64'd536870912), 5);
		random_phase(60, CAP_W'(64'h1FF_FFFF_FFFF), 0);

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("** byte_weighted_lru_cache_unit: PASSED **");
		else
			$display("** byte_weighted_lru_cache_unit: FAILED **");
		$finish;
	end

endmodule

[files.f]
rtl/bwlru_pkg.sv
rtl/bwlru_cell.sv
rtl/byte_weighted_lru_cache_unit.sv
rtl/bwlru_checker.sv
tb/tb.sv
